/* sv/fdf_pkg.sv */
package fdf_pkg;

	// accumulator width, fixed by the number format
	localparam int ACC_BITS = 40;

	// command codes of an input beat
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_FILTER = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_RUN    = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} fdf_state_t;

	// sequencer -> multiply-accumulate unit
	typedef struct packed {
		logic clear;	// start of a new sum
		logic issue;	// a tap read goes out to both memories this cycle
	} mac_ctrl_t;

endpackage

/* sv/fir_filter_direct_form.sv */
// Channel  Handshake                Payload
// in       in_valid / in_stall      command, coef_index, coef_value, sample, last_of_signal
// out      out_valid / out_stall    result_value, saturated
// cfg      cfg_valid / cfg_ready    tap_count
//
// A coefficient load is written at once and leaves the sequencer idle. A sample is summed
// over taps products, where taps is min(tap_count, MAX_TAPS, samples of the current signal):
// one tap per cycle goes through the coefficient and history memory read ports into one
// shared multiplier.
// Reset clears the control state and sets tap_count to 1; both memories hold no reset.
// The finished result sits in an output register, so a new beat is taken while it waits;
// a result is held in the sequencer only if the previous one is still stalled.
module fir_filter_direct_form #(
	parameter int MAX_TAPS     = 64,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input beats
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 command,
	input  logic [$clog2(MAX_TAPS)-1:0]          coef_index,
	input  logic signed [SAMPLE_WIDTH-1:0]       coef_value,
	input  logic signed [SAMPLE_WIDTH-1:0]       sample,
	input  logic                                 last_of_signal,
	// result beats
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]       result_value,
	output logic                                 saturated,
	// tap count register
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [$clog2(MAX_TAPS+1)-1:0]        tap_count
);

	import fdf_pkg::*;

	localparam int IDX_W = $clog2(MAX_TAPS);
	localparam int TAP_W = $clog2(MAX_TAPS + 1);
	localparam logic [TAP_W-1:0] MAX_T = TAP_W'(MAX_TAPS);

	fdf_state_t state_q;

	logic [TAP_W-1:0] tap_count_q;
	logic [IDX_W-1:0] ptr_q;	// next history slot to write
	logic [TAP_W-1:0] seen_q;	// samples of current signal, stops at MAX_TAPS
	logic [TAP_W-1:0] taps_q;	// taps for the sample in flight
	logic [IDX_W-1:0] k_q;		// tap being issued
	logic [IDX_W-1:0] rd_ptr_q;	// history slot of tap k

	logic out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] result_q;
	logic saturated_q;

	logic in_acc;
	logic load_acc;
	logic filt_acc;
	logic coef_we;
	logic [TAP_W-1:0] seen_next;
	logic [TAP_W-1:0] tc_clamped;
	logic [TAP_W-1:0] taps_next;
	logic last_issue;
	logic out_free;

	mac_ctrl_t mac_ctrl;
	logic mac_busy;
	logic signed [SAMPLE_WIDTH-1:0] mac_result;
	logic mac_sat;
	logic [SAMPLE_WIDTH-1:0] coef_rd;
	logic [SAMPLE_WIDTH-1:0] hist_rd;

	// ---------------------------------------------------------------
	// handshakes
	// ---------------------------------------------------------------
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid & ~in_stall;
	assign load_acc  = in_acc & (command == CMD_LOAD);
	assign filt_acc  = in_acc & (command == CMD_FILTER);
	// loads past the store are dropped
	assign coef_we   = load_acc & (TAP_W'(coef_index) < MAX_T);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			tap_count_q <= tap_count;
		end
	end

	// ---------------------------------------------------------------
	// tap count for the next sample
	// ---------------------------------------------------------------
	assign seen_next  = (seen_q < MAX_T) ? seen_q + TAP_W'(1) : seen_q;
	assign tc_clamped = (tap_count_q > MAX_T) ? MAX_T : tap_count_q;
	assign taps_next  = (tc_clamped < seen_next) ? tc_clamped : seen_next;
	assign last_issue = (TAP_W'(k_q) == taps_q - TAP_W'(1));
	assign out_free   = ~out_valid_q | ~out_stall;

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ptr_q    <= '0;
			seen_q   <= '0;
			taps_q   <= '0;
			k_q      <= '0;
			rd_ptr_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (filt_acc) begin
						taps_q   <= taps_next;
						k_q      <= '0;
						rd_ptr_q <= ptr_q;
						ptr_q    <= (ptr_q == IDX_W'(MAX_TAPS - 1)) ? '0 : ptr_q + IDX_W'(1);
						seen_q   <= last_of_signal ? '0 : seen_next;
						// zero taps: sum stays cleared
						state_q  <= (taps_next == '0) ? ST_FINISH : ST_RUN;
					end
				end
				ST_RUN: begin
					k_q      <= k_q + IDX_W'(1);
					rd_ptr_q <= (rd_ptr_q == '0) ? IDX_W'(MAX_TAPS - 1) : rd_ptr_q - IDX_W'(1);
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!mac_busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign mac_ctrl.clear = filt_acc;
	assign mac_ctrl.issue = (state_q == ST_RUN);

	// ---------------------------------------------------------------
	// storage: coefficients and sample history
	// ---------------------------------------------------------------
	fdf_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(MAX_TAPS)
	) u_coef_ram (
		.clk  (clk),
		.we   (coef_we),
		.waddr(coef_index),
		.wdata(coef_value),
		.raddr(k_q),
		.rdata(coef_rd)
	);

	// newest sample is written at accept and read back as tap 0 in the cycle after
	fdf_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(MAX_TAPS)
	) u_hist_ram (
		.clk  (clk),
		.we   (filt_acc),
		.waddr(ptr_q),
		.wdata(sample),
		.raddr(rd_ptr_q),
		.rdata(hist_rd)
	);

	fdf_mac #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (mac_ctrl),
		.coef     (coef_rd),
		.hist     (hist_rd),
		.busy     (mac_busy),
		.result   (mac_result),
		.saturated(mac_sat)
	);

	// ---------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			result_q    <= mac_result;
			saturated_q <= mac_sat;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign saturated    = saturated_q;

`ifndef NO_ASSERTIONS
	a_busy_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		mac_busy |-> (state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("MAC busy outside a tap walk");

	a_tap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (TAP_W'(k_q) < taps_q))
		else $error("tap index past tap count");

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= MAX_T)
		else $error("sample count past MAX_TAPS");

	a_finish_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_valid && out_stall) |=> (state_q == ST_FINISH))
		else $error("result dropped while output stalled");
`endif

endmodule

/* sv/fdf_ram.sv */
module fdf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/fdf_mac.sv */
module fdf_mac #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fdf_pkg::mac_ctrl_t             ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0] coef,
	input  logic signed [SAMPLE_WIDTH-1:0] hist,
	output logic                           busy,
	output logic signed [SAMPLE_WIDTH-1:0] result,
	output logic                           saturated
);

	import fdf_pkg::*;

	localparam int PROD_W = 2 * SAMPLE_WIDTH;
	localparam logic signed [ACC_BITS-1:0] SAT_HI =
		{{(ACC_BITS - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;

	logic                       valid_s1;
	logic                       valid_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_BITS-1:0] acc_q;
	logic signed [ACC_BITS-1:0] shifted;
	logic                       over_hi;
	logic                       under_lo;

	// s1: memory data valid, s2: product valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= ctrl.issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			prod_s2 <= coef * hist;
		end
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + ACC_BITS'(prod_s2);	// wraps mod 2^ACC_BITS
		end
	end

	assign busy = valid_s1 | valid_s2;

	// floor shift back to Q1.(W-1), then clamp
	assign shifted  = acc_q >>> (SAMPLE_WIDTH - 1);
	assign over_hi  = shifted > SAT_HI;
	assign under_lo = shifted < SAT_LO;

	always_comb begin
		saturated = over_hi | under_lo;
		if (over_hi) begin
			result = SAT_HI[SAMPLE_WIDTH-1:0];
		end else if (under_lo) begin
			result = SAT_LO[SAMPLE_WIDTH-1:0];
		end else begin
			result = shifted[SAMPLE_WIDTH-1:0];
		end
	end

endmodule
